@@ rtl/xrs_pkg.sv @@
package xrs_pkg;

    // Stream payload widths
    localparam int IN_TDATA_W  = 96;   // limit(64) | range_scale(32)
    localparam int IN_TUSER_W  = 2;    // mode
    localparam int OUT_TDATA_W = 104;  // value(64) | scaled(33) | pad(7)

    // APB register file
    localparam int APB_AW = 4;
    localparam int APB_DW = 64;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int VALUE_W = 64;
    localparam int SCALE_W = 32;
    localparam int SCALED_W = 33;

    // Request kinds
    localparam logic [MODE_W-1:0] MODE_RAW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BELOW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNIT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RANGE = 2'd3;

    // Register index (taken from paddr[3])
    localparam logic REG_SEED = 1'b0;

    localparam logic [63:0] GOLDEN_SEED = 64'h9E37_79B9_7F4A_7C15;

    // xorshift shifts
    localparam int SH_A = 13;
    localparam int SH_B = 7;
    localparam int SH_C = 17;
    localparam int FRAC_SH = 11;  // 64 - 53

    // Iteration counts of the shared add/sub unit
    localparam int DIV_STEPS = 64;
    localparam int MUL_STEPS = 32;
    localparam int CNT_W     = 6;

    function automatic logic [63:0] xs_next(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        a = x ^ (x << SH_A);
        b = a ^ (a >> SH_B);
        return b ^ (b << SH_C);
    endfunction

    function automatic logic [63:0] seed_load(input logic [63:0] s);
        return (s == 64'd0) ? GOLDEN_SEED : s;
    endfunction

endpackage

@@ rtl/xorshift64_random_source_top.sv @@
// Channel | Dir | Handshake             | Word contents
// s_axis  | in  | tvalid/tready         | tdata: limit[63:0], range_scale[95:64]; tuser: mode
// m_axis  | out | tvalid/tready         | tdata: value[63:0], scaled[96:64], zero pad
// apb     | in  | psel/penable/pready   | seed register at byte address 0 (64-bit data)
//
// Below runs 64 restoring-division steps, range one prep step plus 32 shift-add
// steps, raw and unit go straight to the finish step; all arithmetic runs through
// one 66-bit add/subtract unit under a small sequencer.
// Below with a zero limit goes straight to the finish step and leaves the state untouched.
// Reset loads the golden-ratio state; no clearing pass.
// s_axis_tready is high only in idle; a result waiting on m_axis does not
// block the next input word, only the finish step of the one after it.
module xorshift64_random_source_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [xrs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // limit[63:0], range_scale[95:64]
    input  logic [xrs_pkg::IN_TUSER_W-1:0]    s_axis_tuser,   // mode[1:0]
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [xrs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // value[63:0], scaled[96:64]
    // config
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [xrs_pkg::APB_AW-1:0]        paddr,
    input  logic [xrs_pkg::APB_DW-1:0]        pwdata,
    output logic [xrs_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import xrs_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]          r_fsm;
    logic [CNT_W-1:0]    r_cnt;
    logic [63:0]         r_seed;
    logic [63:0]         r_state;   // generator state
    logic [MODE_W-1:0]   r_mode;
    logic                r_zero;    // below mode with zero limit
    logic                r_neg;     // range result below zero
    logic [64:0]         r_acc;     // remainder / product high part
    logic [63:0]         r_lo;      // dividend shifter / multiplier and product low part
    logic [63:0]         r_opnd;    // divisor / multiplicand
    logic                r_m_valid;
    logic [VALUE_W-1:0]  r_value;
    logic [SCALED_W-1:0] r_scaled;

    logic [VALUE_W-1:0]  in_limit;
    logic [SCALE_W-1:0]  in_scale;
    logic                in_fire;
    logic                in_zero;   // below request with zero limit
    logic                in_step;   // accepted request that advances the state
    logic                cfg_wr;
    logic                out_free;

    // shared add/subtract unit
    logic [64:0] add_a;
    logic [64:0] add_b;
    logic        add_sub;
    logic [65:0] add_sum;

    logic [53:0]         d2;
    logic [SCALED_W-1:0] q_mag;
    logic                sticky;
    logic [SCALED_W-1:0] q_up;

    assign in_limit = s_axis_tdata[VALUE_W-1:0];
    assign in_scale = s_axis_tdata[VALUE_W +: SCALE_W];
    assign s_axis_tready = (r_fsm == ST_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign in_zero  = (s_axis_tuser == MODE_BELOW) && (in_limit == 64'd0);
    assign in_step  = in_fire && !in_zero;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[3] == REG_SEED);
    assign out_free = !r_m_valid || m_axis_tready;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_SEED) ? r_seed : '0;

    assign d2 = {r_state[63:FRAC_SH], 1'b0};

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (r_fsm)
            ST_PREP: begin
                // 2^53 - 2t
                add_a   = 65'(1) << 53;
                add_b   = {11'd0, d2};
                add_sub = 1'b1;
            end
            ST_DIV: begin
                add_a   = {r_acc[63:0], r_lo[63]};
                add_b   = {1'b0, r_opnd};
                add_sub = 1'b1;
            end
            ST_MUL: begin
                add_a   = r_acc;
                add_b   = r_lo[0] ? {1'b0, r_opnd} : '0;
                add_sub = 1'b0;
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + (add_sub ? ~{1'b0, add_b} : {1'b0, add_b})
                   + {65'd0, add_sub};

    // product = {r_acc[53:0], r_lo[31:0]}; result is product >> 53
    assign q_mag  = r_acc[53:21];
    assign sticky = (|r_acc[20:0]) || (|r_lo[31:0]);
    assign q_up   = q_mag + {{(SCALED_W-1){1'b0}}, sticky};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= ST_IDLE;
            r_cnt     <= '0;
            r_seed    <= '0;
            r_state   <= GOLDEN_SEED;
            r_m_valid <= 1'b0;
        end else begin
            if (r_fsm == ST_FIN && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_fsm)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_mode <= s_axis_tuser;
                        r_zero <= in_zero;
                        r_cnt  <= '0;
                        r_acc  <= '0;
                        r_opnd <= in_limit;
                        r_lo   <= (s_axis_tuser == MODE_RANGE) ? {32'd0, in_scale}
                                                               : xs_next(r_state);
                        if (in_zero) begin
                            r_fsm <= ST_FIN;
                        end else begin
                            case (s_axis_tuser)
                                MODE_BELOW: r_fsm <= ST_DIV;
                                MODE_RANGE: r_fsm <= ST_PREP;
                                default:    r_fsm <= ST_FIN;
                            endcase
                        end
                    end
                end
                ST_PREP: begin
                    r_neg <= !r_state[63];
                    if (r_state[63]) begin
                        r_opnd <= {11'd0, d2[52:0]};
                    end else begin
                        r_opnd <= {10'd0, add_sum[53:0]};
                    end
                    r_fsm <= ST_MUL;
                end
                ST_DIV: begin
                    // restoring step: keep difference when no borrow
                    r_acc <= add_sum[65] ? add_a : add_sum[64:0];
                    r_lo  <= {r_lo[62:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_fsm <= ST_FIN;
                    end
                end
                ST_MUL: begin
                    r_acc <= {1'b0, add_sum[64:1]};
                    r_lo  <= {32'd0, add_sum[0], r_lo[31:1]};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_fsm <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_scaled <= (r_mode != MODE_RANGE) ? '0 :
                                    r_neg ? (~q_up + SCALED_W'(1)) : q_mag;
                        case (r_mode)
                            MODE_RAW:   r_value <= r_state;
                            MODE_BELOW: r_value <= r_zero ? '0 : r_acc[63:0];
                            MODE_UNIT:  r_value <= {{FRAC_SH{1'b0}}, r_state[63:FRAC_SH]};
                            MODE_RANGE: r_value <= '0;
                            default:    r_value <= '0;
                        endcase
                        r_fsm <= ST_IDLE;
                    end
                end
                default: r_fsm <= ST_IDLE;
            endcase
            // the user must write the seed only while idle (the block does not enforce it); writes reload the generator
            if (cfg_wr) begin
                r_seed  <= pwdata;
                r_state <= seed_load(pwdata);
            end else if (in_step) begin
                r_state <= xs_next(r_state);
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-VALUE_W-SCALED_W){1'b0}}, r_scaled, r_value};

    a_div_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tuser == MODE_BELOW && in_limit != 64'd0)
        |=> (r_fsm == ST_DIV && r_cnt == '0 && r_acc == '0))
        else $error("division not set up on below request");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_DIV) |-> (r_acc < {1'b0, r_opnd}))
        else $error("partial remainder not below limit");

    a_div_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_DIV) |=> (r_fsm == ST_DIV || r_fsm == ST_FIN))
        else $error("division left early");

    a_fin_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_FIN && out_free) |=> (r_m_valid && r_fsm == ST_IDLE))
        else $error("result not loaded from finish step");

endmodule
